[rtl/tct_pkg.sv]
`timescale 1ns / 1ps

package tct_pkg;

    // Default sizes
    localparam int TCT_DEPTH_DEF    = 16;
    localparam int TCT_ID_WIDTH_DEF = 16;

    // Field widths
    localparam int OP_W     = 3;
    localparam int TID_W    = 16;
    localparam int PRIO_W   = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int TSTATE_W = 2;

    // Request codes
    localparam logic [OP_W-1:0] OP_CREATE    = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd1;
    localparam logic [OP_W-1:0] OP_ACTIVATE  = 3'd2;
    localparam logic [OP_W-1:0] OP_TERMINATE = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_STATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_PARAM = 3'd4;

    // Thread states
    localparam logic [TSTATE_W-1:0] TS_DEAD  = 2'd0;
    localparam logic [TSTATE_W-1:0] TS_READY = 2'd1;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture request, restart scan
        logic reject;  // bad parameter, no table access
        logic scan;    // issue next slot read
        logic commit;  // act on the slot under compare
        logic miss;    // scan ran out
        logic emit;    // move result to output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pre_bad; // unknown request or zero entry on create
        logic hit;     // slot under compare is the one sought
        logic last;    // slot under compare is the final one
    } t_dp_sts;

endpackage

[rtl/thread_control_table.sv]
`timescale 1ns / 1ps

// Thread control table. Holds TABLE_DEPTH thread entries (id, priority,
// stack size, entry address, parameter word, state) and serves one request
// at a time: create, delete, activate, terminate or query state. Every
// request yields exactly one result with a status code and, for a query,
// the thread state. Create takes the lowest free slot; the others act on
// the lowest valid slot whose id matches (low ID_WIDTH bits of the id).
// Timing: a request walks the table one slot per cycle through a single
// read port, stopping at the first slot that answers it or at the last
// slot. A rejected request (unknown code, or create with zero entry
// address) skips the scan. A new request is accepted once the previous one
// has moved into the output register, even if that result is still stalled.
// Of the table, only the valid bits are reset; no clearing pass is needed.
module thread_control_table import tct_pkg::*; #(
    parameter int TABLE_DEPTH = TCT_DEPTH_DEF,
    parameter int ID_WIDTH    = TCT_ID_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [TID_W-1:0]    i_thread_id,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  logic [WORD_W-1:0]   i_stack_size,
    input  logic [WORD_W-1:0]   i_entry_address,
    input  logic [WORD_W-1:0]   i_param_value,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [TSTATE_W-1:0] o_thread_state
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer: accept, decide, scan, deliver
    tct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Table storage, slot compare and result registers
    tct_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_operation     (i_operation),
        .i_thread_id     (i_thread_id),
        .i_priority_req  (i_priority_req),
        .i_stack_size    (i_stack_size),
        .i_entry_address (i_entry_address),
        .i_param_value   (i_param_value),
        .o_status        (o_status),
        .o_thread_state  (o_thread_state)
    );

endmodule

[rtl/tct_ctrl.sv]
`timescale 1ns / 1ps

module tct_ctrl import tct_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.pre_bad) begin
                    o_cmd.reject = 1'b1;
                    n_state      = S_FINISH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_FINISH;
                end else if (i_sts.last) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DECIDE))
        else $error("accepted request did not move to decide");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && (i_sts.hit || i_sts.last)) |=> (r_state == S_FINISH))
        else $error("scan did not finish at hit or last slot");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> w_out_free)
        else $error("result emitted over a pending one");

endmodule

[rtl/tct_dp.sv]
`timescale 1ns / 1ps

module tct_dp import tct_pkg::*; #(
    parameter int TABLE_DEPTH = TCT_DEPTH_DEF,
    parameter int ID_WIDTH    = TCT_ID_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [TID_W-1:0]    i_thread_id,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  logic [WORD_W-1:0]   i_stack_size,
    input  logic [WORD_W-1:0]   i_entry_address,
    input  logic [WORD_W-1:0]   i_param_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [TSTATE_W-1:0] o_thread_state
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    // Table: valid bits in flops, the rest in memory
    logic                r_valid     [TABLE_DEPTH];
    logic [ID_WIDTH-1:0] r_mem_id    [TABLE_DEPTH];
    logic [TSTATE_W-1:0] r_mem_state [TABLE_DEPTH];
    logic [PRIO_W-1:0]   r_mem_prio  [TABLE_DEPTH];
    logic [WORD_W-1:0]   r_mem_stack [TABLE_DEPTH];
    logic [WORD_W-1:0]   r_mem_entry [TABLE_DEPTH];
    logic [WORD_W-1:0]   r_mem_param [TABLE_DEPTH];

    // Captured request
    logic [OP_W-1:0]     r_req_op;
    logic [ID_WIDTH-1:0] r_req_id;
    logic [PRIO_W-1:0]   r_req_prio;
    logic [WORD_W-1:0]   r_req_stack;
    logic [WORD_W-1:0]   r_req_entry;
    logic [WORD_W-1:0]   r_req_param;

    // Scan pipe: address, then registered read and compare
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_cmp_vld;
    logic                r_rd_valid;
    logic [ID_WIDTH-1:0] r_rd_id;
    logic [TSTATE_W-1:0] r_rd_state;

    logic [STATUS_W-1:0] r_res_status;
    logic [TSTATE_W-1:0] r_res_tstate;
    logic [STATUS_W-1:0] n_res_status;
    logic [TSTATE_W-1:0] n_res_tstate;

    logic [2*TID_W-1:0]  w_id_ext;
    logic                w_is_create;
    logic                w_rd_dead;
    logic                w_st_we;
    logic [TSTATE_W-1:0] w_st_wdata;
    logic                w_vld_set;
    logic                w_vld_clr;

    assign w_id_ext    = {{TID_W{1'b0}}, i_thread_id};
    assign w_is_create = (r_req_op == OP_CREATE);
    assign w_rd_dead   = (r_rd_state == TS_DEAD);

    assign o_sts.pre_bad = (r_req_op > OP_QUERY) || (w_is_create && (r_req_entry == '0));
    assign o_sts.hit     = r_cmp_vld && (w_is_create ? !r_rd_valid
                                                     : (r_rd_valid && (r_rd_id == r_req_id)));
    assign o_sts.last    = r_cmp_vld && (r_cmp_idx == IDX_LAST);

    // Action on the slot found
    always_comb begin
        n_res_status = ST_OK;
        n_res_tstate = TS_DEAD;
        w_st_we      = 1'b0;
        w_st_wdata   = TS_DEAD;
        w_vld_set    = 1'b0;
        w_vld_clr    = 1'b0;
        unique case (r_req_op)
            OP_CREATE: begin
                w_st_we   = 1'b1;
                w_vld_set = 1'b1;
            end
            OP_DELETE: begin
                if (w_rd_dead) w_vld_clr = 1'b1;
                else           n_res_status = ST_BAD_STATE;
            end
            OP_ACTIVATE: begin
                if (w_rd_dead) begin
                    w_st_we    = 1'b1;
                    w_st_wdata = TS_READY;
                end else begin
                    n_res_status = ST_BAD_STATE;
                end
            end
            OP_TERMINATE: begin
                if (!w_rd_dead) w_st_we = 1'b1;
                else            n_res_status = ST_BAD_STATE;
            end
            OP_QUERY: n_res_tstate = r_rd_state;
            default:  n_res_status = ST_BAD_PARAM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) r_valid[k] <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= 1'b1;
            end
            if (i_cmd.commit && w_vld_set) r_valid[r_cmp_idx] <= 1'b1;
            if (i_cmd.commit && w_vld_clr) r_valid[r_cmp_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_op    <= i_operation;
            r_req_id    <= w_id_ext[ID_WIDTH-1:0];
            r_req_prio  <= i_priority_req;
            r_req_stack <= i_stack_size;
            r_req_entry <= i_entry_address;
            r_req_param <= i_param_value;
            r_idx       <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.scan) begin
            r_cmp_idx  <= r_idx;
            r_rd_valid <= r_valid[r_idx];
            r_rd_id    <= r_mem_id[r_idx];
            r_rd_state <= r_mem_state[r_idx];
        end
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_is_create) begin
            r_mem_id[r_cmp_idx]    <= r_req_id;
            r_mem_prio[r_cmp_idx]  <= r_req_prio;
            r_mem_stack[r_cmp_idx] <= r_req_stack;
            r_mem_entry[r_cmp_idx] <= r_req_entry;
            r_mem_param[r_cmp_idx] <= r_req_param;
        end
        if (i_cmd.commit && w_st_we) r_mem_state[r_cmp_idx] <= w_st_wdata;
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.reject) begin
            r_res_status <= ST_BAD_PARAM;
            r_res_tstate <= TS_DEAD;
        end else if (i_cmd.commit) begin
            r_res_status <= n_res_status;
            r_res_tstate <= n_res_tstate;
        end else if (i_cmd.miss) begin
            r_res_status <= w_is_create ? ST_FULL : ST_BAD_ID;
            r_res_tstate <= TS_DEAD;
        end
        if (i_cmd.emit) begin
            o_status       <= r_res_status;
            o_thread_state <= r_res_tstate;
        end
    end

    a_commit_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (r_cmp_vld && o_sts.hit))
        else $error("commit without a matching slot");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && !i_cmd.load) ##1 (i_cmd.scan && r_cmp_vld && $past(r_cmp_vld))
        |-> (r_cmp_idx == $past(r_cmp_idx) + 1'b1))
        else $error("scan skipped a slot");

    a_miss_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.miss |-> o_sts.last)
        else $error("miss before the last slot");

endmodule
